/* hw/rtl/ptt_pkg.sv */
// shared types, codes and constants of the periodic task timer table
package ptt_pkg;

	localparam int TASK_SLOTS_DEF = 32;
	localparam int MAX_RESULTS    = 32;
	localparam int MS_PER_SEC     = 1000;

	localparam int FUNC_W  = 2;
	localparam int ID_W    = 5;
	localparam int INTV_W  = 32;
	localparam int NOW_W   = 48;
	localparam int DUE_W   = 49;
	localparam int RUNS_W  = 32;
	localparam int STAT_W  = 2;
	localparam int PROD_W  = 42;
	localparam int FIRED_W = $clog2(MAX_RESULTS + 1);

	typedef enum logic [FUNC_W-1:0] {
		FN_TICK   = 2'd0,
		FN_ADD    = 2'd1,
		FN_REMOVE = 2'd2,
		FN_ENABLE = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_REJ  = 2'd1,
		ST_NONE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_ADD_WR,
		S_SCAN,
		S_DRAIN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [INTV_W-1:0] interval;
		logic [DUE_W-1:0]  next_due;
		logic [RUNS_W-1:0] fire_count;
	} slot_rec_t;

endpackage

/* hw/rtl/ptt_if.sv */
// valid/ready channel interfaces for command and response words
interface ptt_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [ptt_pkg::FUNC_W-1:0]    func;
	logic [ptt_pkg::ID_W-1:0]      task_id;
	logic [ptt_pkg::INTV_W-1:0]    period_sec;
	logic                          enable_flag;
	logic [ptt_pkg::NOW_W-1:0]     now_ms;

	modport source (output valid, func, task_id, period_sec, enable_flag, now_ms,
		input ready);
	modport sink (input valid, func, task_id, period_sec, enable_flag, now_ms,
		output ready);
endinterface

interface ptt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ptt_pkg::STAT_W-1:0]    status;
	logic [ptt_pkg::ID_W-1:0]      slot_index;
	logic [ptt_pkg::RUNS_W-1:0]    runs_so_far;
	logic                          last;

	modport source (output valid, status, slot_index, runs_so_far, last, input ready);
	modport sink (input valid, status, slot_index, runs_so_far, last, output ready);
endinterface

/* hw/rtl/periodic_task_timer_table_top.sv */
// periodic task timer table: slot memory, scan pipeline and command sequencer
//
// channel | role | word
// cmd     | sink | func, task_id, period_sec, enable_flag, now_ms
// rsp     | src  | status, slot_index, runs_so_far, last
//
// one command at a time; cmd is ready only while the sequencer is idle
// tick: the scan reads one slot record a cycle, unless a firing waits on a full
//   rsp register, through a three-stage read, multiply, write-back pipeline
// add: free-slot search walks the active bits
// remove, enable, zero-time ticks and immediate rejects go straight to the rsp word
// reset clears active and enabled flops at once; an rsp stall freezes the scan
//   only while a new firing waits to be pushed
module periodic_task_timer_table_top #(
	parameter int TASK_SLOTS = ptt_pkg::TASK_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ptt_cmd_if.sink   cmd,
	ptt_rsp_if.source rsp
);

	localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CW = $clog2(TASK_SLOTS + 1);

	ptt_pkg::state_t state_q, state_d;

	logic [TASK_SLOTS-1:0] act_q, ena_q;
	logic [CW-1:0]         cnt_q;
	logic [IW-1:0]         cnt_idx, id_idx;

	logic [ptt_pkg::INTV_W-1:0] interval_q;
	logic [ptt_pkg::NOW_W-1:0]  now_q;
	logic [ptt_pkg::PROD_W-1:0] prod_q;

	ptt_pkg::slot_rec_t mem_q [TASK_SLOTS];
	ptt_pkg::slot_rec_t rd_q;

	logic                       v_s1_q, v_s2_q;
	logic [IW-1:0]              idx_s1, idx_s2;
	logic                       due_s2;
	logic [ptt_pkg::PROD_W-1:0] prod_s2;
	logic [ptt_pkg::RUNS_W-1:0] cnt_s2;
	logic [ptt_pkg::INTV_W-1:0] intv_s2;

	logic                       pend_v_q;
	logic [IW-1:0]              pend_idx_q;
	logic [ptt_pkg::RUNS_W-1:0] pend_cnt_q;
	logic [ptt_pkg::FIRED_W-1:0] fired_q;

	logic                       out_v_q;
	logic [ptt_pkg::STAT_W-1:0] out_status_q;
	logic [ptt_pkg::ID_W-1:0]   out_slot_q;
	logic [ptt_pkg::RUNS_W-1:0] out_runs_q;
	logic                       out_last_q;

	logic [ptt_pkg::STAT_W-1:0] resp_status_q, resp_status_d;
	logic [ptt_pkg::ID_W-1:0]   resp_slot_q, resp_slot_d;
	logic                       resp_ld;

	logic                       cmd_rdy, accept, id_ok, out_free, fire_s2, rep;
	logic                       issue, adv, more, cnt_clr, cnt_inc, pend_ld;
	logic                       push, push_last;
	logic [ptt_pkg::STAT_W-1:0] push_status;
	logic [ptt_pkg::ID_W-1:0]   push_slot;
	logic [ptt_pkg::RUNS_W-1:0] push_runs;
	logic                       wr_en;
	logic [IW-1:0]              wr_addr;
	ptt_pkg::slot_rec_t         wr_data;
	logic                       add_set, rm_clr, en_wr;

	assign cnt_idx  = cnt_q[IW-1:0];
	assign id_idx   = IW'(cmd.task_id);
	assign id_ok    = (32'(cmd.task_id) < TASK_SLOTS) && act_q[id_idx];
	assign accept   = cmd.valid && cmd_rdy;
	assign out_free = !out_v_q || rsp.ready;
	assign fire_s2  = v_s2_q && due_s2;
	assign rep      = fired_q < ptt_pkg::FIRED_W'(ptt_pkg::MAX_RESULTS);
	assign more     = cnt_q < CW'(TASK_SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd_rdy       = 1'b0;
		issue         = 1'b0;
		adv           = 1'b1;
		cnt_clr       = 1'b0;
		cnt_inc       = 1'b0;
		pend_ld       = 1'b0;
		push          = 1'b0;
		push_last     = 1'b1;
		push_status   = ptt_pkg::ST_OK;
		push_slot     = '0;
		push_runs     = '0;
		wr_en         = 1'b0;
		wr_addr       = cnt_idx;
		wr_data       = '0;
		add_set       = 1'b0;
		rm_clr        = 1'b0;
		en_wr         = 1'b0;
		resp_ld       = 1'b0;
		resp_status_d = ptt_pkg::ST_REJ;
		resp_slot_d   = '0;
		case (state_q)
			ptt_pkg::S_IDLE: begin
				cmd_rdy = 1'b1;
				if (cmd.valid) begin
					cnt_clr = 1'b1;
					case (cmd.func)
						ptt_pkg::FN_TICK: begin
							if (cmd.now_ms == '0) begin
								resp_ld       = 1'b1;
								resp_status_d = ptt_pkg::ST_NONE;
								state_d       = ptt_pkg::S_RESP;
							end else begin
								state_d = ptt_pkg::S_SCAN;
							end
						end
						ptt_pkg::FN_ADD: begin
							if (cmd.period_sec == '0) begin
								resp_ld = 1'b1;
								state_d = ptt_pkg::S_RESP;
							end else begin
								state_d = ptt_pkg::S_FIND;
							end
						end
						ptt_pkg::FN_REMOVE: begin
							resp_ld = 1'b1;
							rm_clr  = id_ok;
							if (id_ok) resp_status_d = ptt_pkg::ST_OK;
							state_d = ptt_pkg::S_RESP;
						end
						ptt_pkg::FN_ENABLE: begin
							resp_ld = 1'b1;
							en_wr   = id_ok;
							if (id_ok) resp_status_d = ptt_pkg::ST_OK;
							state_d = ptt_pkg::S_RESP;
						end
						default: begin
							state_d = ptt_pkg::S_IDLE;
						end
					endcase
				end
			end
			ptt_pkg::S_FIND: begin
				if (!act_q[cnt_idx]) begin
					state_d = ptt_pkg::S_ADD_WR;
				end else if (cnt_q == CW'(TASK_SLOTS - 1)) begin
					resp_ld = 1'b1;
					state_d = ptt_pkg::S_RESP;
				end else begin
					cnt_inc = 1'b1;
				end
			end
			ptt_pkg::S_ADD_WR: begin
				wr_en              = 1'b1;
				wr_data.interval   = interval_q;
				wr_data.next_due   = ptt_pkg::DUE_W'(now_q) + ptt_pkg::DUE_W'(prod_q);
				wr_data.fire_count = '0;
				add_set            = 1'b1;
				resp_ld            = 1'b1;
				resp_status_d      = ptt_pkg::ST_OK;
				resp_slot_d        = ptt_pkg::ID_W'(cnt_idx);
				state_d            = ptt_pkg::S_RESP;
			end
			ptt_pkg::S_SCAN: begin
				adv     = !(fire_s2 && rep && pend_v_q && !out_free);
				issue   = adv && more;
				cnt_inc = issue;
				if (fire_s2 && adv) begin
					wr_en              = 1'b1;
					wr_addr            = idx_s2;
					wr_data.interval   = intv_s2;
					wr_data.next_due   = ptt_pkg::DUE_W'(now_q) + ptt_pkg::DUE_W'(prod_s2);
					wr_data.fire_count = cnt_s2;
					pend_ld            = rep;
					push               = rep && pend_v_q;
				end
				push_last = 1'b0;
				push_slot = ptt_pkg::ID_W'(pend_idx_q);
				push_runs = pend_cnt_q;
				if (!more && !v_s1_q && !v_s2_q) state_d = ptt_pkg::S_DRAIN;
			end
			ptt_pkg::S_DRAIN: begin
				push = out_free;
				if (pend_v_q) begin
					push_slot = ptt_pkg::ID_W'(pend_idx_q);
					push_runs = pend_cnt_q;
				end else begin
					push_status = ptt_pkg::ST_NONE;
				end
				if (out_free) state_d = ptt_pkg::S_IDLE;
			end
			ptt_pkg::S_RESP: begin
				push        = out_free;
				push_status = resp_status_q;
				push_slot   = resp_slot_q;
				if (out_free) state_d = ptt_pkg::S_IDLE;
			end
			default: begin
				state_d = ptt_pkg::S_IDLE;
			end
		endcase
	end

	// slot record memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (issue) rd_q <= mem_q[cnt_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= '0;
			ena_q    <= '0;
			cnt_q    <= '0;
			v_s1_q   <= 1'b0;
			v_s2_q   <= 1'b0;
			pend_v_q <= 1'b0;
			fired_q  <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (add_set) begin
				act_q[cnt_idx] <= 1'b1;
				ena_q[cnt_idx] <= 1'b1;
			end
			if (rm_clr) act_q[id_idx] <= 1'b0;
			if (en_wr) ena_q[id_idx] <= cmd.enable_flag;
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (adv) begin
				v_s1_q <= issue;
				v_s2_q <= v_s1_q;
			end
			if (accept) begin
				pend_v_q <= 1'b0;
				fired_q  <= '0;
			end else if (pend_ld) begin
				pend_v_q <= 1'b1;
				fired_q  <= fired_q + 1'b1;
			end
			if (push) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			interval_q <= cmd.period_sec;
			now_q      <= cmd.now_ms;
		end
		prod_q <= ptt_pkg::PROD_W'(interval_q) * ptt_pkg::PROD_W'(ptt_pkg::MS_PER_SEC);
		if (adv) begin
			idx_s1  <= cnt_idx;
			idx_s2  <= idx_s1;
			due_s2  <= v_s1_q && act_q[idx_s1] && ena_q[idx_s1]
				&& ({1'b0, now_q} >= rd_q.next_due);
			prod_s2 <= ptt_pkg::PROD_W'(rd_q.interval)
				* ptt_pkg::PROD_W'(ptt_pkg::MS_PER_SEC);
			cnt_s2  <= rd_q.fire_count + 1'b1;
			intv_s2 <= rd_q.interval;
		end
		if (pend_ld) begin
			pend_idx_q <= idx_s2;
			pend_cnt_q <= cnt_s2;
		end
		if (resp_ld) begin
			resp_status_q <= resp_status_d;
			resp_slot_q   <= resp_slot_d;
		end
		if (push) begin
			out_status_q <= push_status;
			out_slot_q   <= push_slot;
			out_runs_q   <= push_runs;
			out_last_q   <= push_last;
		end
	end

	assign cmd.ready       = cmd_rdy;
	assign rsp.valid       = out_v_q;
	assign rsp.status      = out_status_q;
	assign rsp.slot_index  = out_slot_q;
	assign rsp.runs_so_far = out_runs_q;
	assign rsp.last        = out_last_q;

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_rdy |-> !v_s1_q && !v_s2_q)
		else $error("command taken while scan pipeline busy");

	a_fired_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fired_q <= ptt_pkg::FIRED_W'(ptt_pkg::MAX_RESULTS))
		else $error("fired count beyond result limit");

	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptt_pkg::S_DRAIN) && out_free |=> state_q == ptt_pkg::S_IDLE)
		else $error("drain did not return to idle");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("response word overwritten");

	a_pend_scope: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q && (state_q != ptt_pkg::S_IDLE) |->
		(state_q == ptt_pkg::S_SCAN || state_q == ptt_pkg::S_DRAIN))
		else $error("pending firing outside a tick");

endmodule
